[hw/rtl/boundary_tag_first_fit_heap_assert.svh]
// Assertion macros for the boundary tag heap allocator.
`ifndef BOUNDARY_TAG_FIRST_FIT_HEAP_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_HEAP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BTFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/btff_pkg.sv]
// Package: constants and codes for the boundary tag heap allocator.
package btff_pkg;
  localparam int ADDR_W     = 14;
  localparam int POOL_WORDS = 16384;
  localparam int WORD_W     = 32;
  localparam int STEP_W     = ADDR_W + 1;
  localparam int HDR_WORDS  = 3;
  localparam int FTR_WORDS  = 1;
  localparam int TAG_WORDS  = HDR_WORDS + FTR_WORDS;
  localparam int USED_BIT   = 31;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FAIL   = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;
endpackage

[hw/rtl/btff_req_if.sv]
// Request channel interface: action, size and address to free.
interface btff_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [btff_pkg::ADDR_W-1:0] request_size;
  logic [btff_pkg::ADDR_W-1:0] free_address;
  modport source (output valid, action, request_size, free_address, input ready);
  modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

[hw/rtl/btff_rsp_if.sv]
// Response channel interface: data address and status.
interface btff_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [btff_pkg::ADDR_W-1:0] data_address;
  logic                        status;
  modport source (output valid, data_address, status, input ready);
  modport sink   (input valid, data_address, status, output ready);
endinterface

[hw/rtl/boundary_tag_first_fit_heap.sv]
// Top level: first-fit heap allocator with boundary tags and coalescing.
// Usage:
//   in_ch (sink): action 0 allocates request_size words, action 1 frees the
//   block whose data word is free_address. One transfer at a time.
//   out_ch (source): one result per request, data_address and status
//   (status 1 when no free block fits an allocation).
// Steps: allocate walks the free list, then splits the chosen block or
//   unlinks it (it fails at once when the list is empty); free clears the
//   used flags, then merges right and left or links the block into the list.
//   Each step makes at most one access of the single-port pool memory, which
//   sets the rate; the list walk dominates for fragmented pools.
// Throughput: one request in flight; in_ch.ready is high only when idle.
// Reset: rst_n (synchronous, active low) starts a clearing pass that
//   writes all 16384 pool words, setting up the initial single free block;
//   no request is taken until it ends.
// Stall: a finished result waits in the output register while out_ch.ready
//   is low; a new request may be accepted meanwhile, and that request holds
//   in its last step until the output register frees.
`include "boundary_tag_first_fit_heap_assert.svh"

module boundary_tag_first_fit_heap (
  input  logic       clk,
  input  logic       rst_n,
  btff_req_if.sink   in_ch,
  btff_rsp_if.source out_ch
);
  import btff_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_CLR = 6'd1,  S_DONE = 6'd2;
  localparam logic [5:0] S_F0 = 6'd3,  S_F1 = 6'd4,  S_F2 = 6'd5,  S_F3 = 6'd6;
  localparam logic [5:0] S_F4 = 6'd7,  S_F5 = 6'd8,  S_F6 = 6'd9,  S_F7 = 6'd10;
  localparam logic [5:0] S_F8 = 6'd11, S_F9 = 6'd12, S_F10 = 6'd13, S_F11 = 6'd14;
  localparam logic [5:0] S_F12 = 6'd15;
  localparam logic [5:0] S_L0 = 6'd16, S_L1 = 6'd17, S_L2 = 6'd18, S_L3 = 6'd19;
  localparam logic [5:0] S_L4 = 6'd20, S_L5 = 6'd21, S_L6 = 6'd22, S_L7 = 6'd23;
  localparam logic [5:0] S_L8 = 6'd24, S_L9 = 6'd25;
  localparam logic [5:0] S_N0 = 6'd26, S_N1 = 6'd27, S_N2 = 6'd28, S_N3 = 6'd29;
  localparam logic [5:0] S_N4 = 6'd30, S_N5 = 6'd31, S_N6 = 6'd32, S_N7 = 6'd33;
  localparam logic [5:0] S_N8 = 6'd34, S_N9 = 6'd35;
  localparam logic [5:0] S_A0 = 6'd36, S_A1 = 6'd37, S_A2 = 6'd38, S_A3 = 6'd39;
  localparam logic [5:0] S_A4 = 6'd40, S_A5 = 6'd41, S_A6 = 6'd42, S_A7 = 6'd43;
  localparam logic [5:0] S_A8 = 6'd44, S_A9 = 6'd45, S_A10 = 6'd46, S_A11 = 6'd47;

  localparam addr_t A_HDR   = addr_t'(HDR_WORDS);
  localparam addr_t A_ONE   = addr_t'(1);
  localparam addr_t A_TWO   = addr_t'(2);
  localparam addr_t A_LAST  = addr_t'(POOL_WORDS - 1);
  localparam word_t W_TAG   = word_t'(TAG_WORDS);
  localparam word_t W_INIT  = word_t'(POOL_WORDS - TAG_WORDS);
  localparam word_t USED    = word_t'(1) << USED_BIT;

  word_t pool_mem [POOL_WORDS];
  word_t mem_q;
  addr_t mem_addr;
  word_t mem_wd;
  logic  mem_we, mem_re;

  logic [5:0]        state_r, state_nxt;
  addr_t             h_r, h_nxt, f_r, f_nxt, r_r, r_nxt, n_r, n_nxt;
  addr_t             e_r, e_nxt, req_r, req_nxt, cnt_r, cnt_nxt, res_r, res_nxt;
  logic              ev_r, ev_nxt, fail_r, fail_nxt;
  word_t             t_r, t_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              ovalid_r, ovalid_nxt, ostat_r, ostat_nxt;
  addr_t             odata_r, odata_nxt;
  word_t             sum;
  logic              in_xfer;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_xfer             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.data_address = odata_r;
  assign out_ch.status       = ostat_r;

  always_ff @(posedge clk) begin
    if (mem_re) mem_q <= pool_mem[mem_addr];
    if (mem_we) pool_mem[mem_addr] <= mem_wd;
  end

  always_comb begin
    state_nxt = state_r;  h_nxt = h_r;  f_nxt = f_r;  r_nxt = r_r;  n_nxt = n_r;
    e_nxt = e_r;  ev_nxt = ev_r;  req_nxt = req_r;  cnt_nxt = cnt_r;  res_nxt = res_r;
    fail_nxt = fail_r;  t_nxt = t_r;  steps_nxt = steps_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    odata_nxt = odata_r;  ostat_nxt = ostat_r;
    mem_addr = '0;  mem_wd = '0;  mem_we = 1'b0;  mem_re = 1'b0;
    sum = t_r + mem_q + W_TAG;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_addr = cnt_r;
        mem_wd = (cnt_r == '0 || cnt_r == A_LAST) ? W_INIT : '0;
        cnt_nxt = cnt_r + A_ONE;
        if (cnt_r == A_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_ch.request_size;
          h_nxt = in_ch.free_address - A_HDR;
          res_nxt = '0;
          fail_nxt = ST_OK;
          state_nxt = (in_ch.action == ACT_FREE) ? S_F0 : S_A0;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          odata_nxt = res_r;
          ostat_nxt = fail_r;
          state_nxt = S_IDLE;
        end
      end
      // free: clear used flags, then try merging with the right neighbor
      S_F0: begin mem_re = 1'b1; mem_addr = h_r; state_nxt = S_F1; end
      S_F1: begin
        mem_we = 1'b1; mem_addr = h_r; mem_wd = mem_q & ~USED;
        t_nxt = mem_q; state_nxt = S_F2;
      end
      S_F2: begin
        f_nxt = h_r + A_HDR + t_r[ADDR_W-1:0];
        mem_re = 1'b1; mem_addr = h_r + A_HDR + t_r[ADDR_W-1:0]; state_nxt = S_F3;
      end
      S_F3: begin
        mem_we = 1'b1; mem_addr = f_r; mem_wd = mem_q & ~USED; state_nxt = S_F4;
      end
      S_F4: begin
        if (f_r != A_LAST) begin
          r_nxt = f_r + A_ONE;
          mem_re = 1'b1; mem_addr = f_r + A_ONE; state_nxt = S_F5;
        end else begin
          state_nxt = S_L0;
        end
      end
      S_F5: begin
        if (!mem_q[USED_BIT]) begin
          f_nxt = r_r + A_HDR + mem_q[ADDR_W-1:0];
          mem_re = 1'b1; mem_addr = r_r + A_HDR + mem_q[ADDR_W-1:0];
          state_nxt = S_F6;
        end else begin
          state_nxt = S_L0;
        end
      end
      S_F6: begin t_nxt = mem_q; mem_re = 1'b1; mem_addr = h_r; state_nxt = S_F7; end
      S_F7: begin
        mem_we = 1'b1; mem_addr = f_r; mem_wd = sum; t_nxt = sum; state_nxt = S_F8;
      end
      S_F8: begin mem_we = 1'b1; mem_addr = h_r; mem_wd = t_r; state_nxt = S_F9; end
      S_F9: begin mem_re = 1'b1; mem_addr = r_r + A_ONE; state_nxt = S_F10; end
      S_F10: begin
        if (mem_q[ADDR_W-1:0] == r_r) begin
          ev_nxt = 1'b0; state_nxt = S_L0;
        end else begin
          e_nxt = mem_q[ADDR_W-1:0]; ev_nxt = 1'b1; n_nxt = mem_q[ADDR_W-1:0];
          mem_re = 1'b1; mem_addr = r_r + A_TWO; state_nxt = S_F11;
        end
      end
      S_F11: begin
        // unlink right block: next.prev = prev, then prev.next = next
        r_nxt = mem_q[ADDR_W-1:0];
        mem_we = 1'b1; mem_addr = n_r + A_TWO; mem_wd = word_t'(mem_q[ADDR_W-1:0]);
        state_nxt = S_F12;
      end
      S_F12: begin
        mem_we = 1'b1; mem_addr = r_r + A_ONE; mem_wd = word_t'(n_r); state_nxt = S_L0;
      end
      // left merge
      S_L0: begin mem_re = 1'b1; mem_addr = h_r; state_nxt = S_L1; end
      S_L1: begin
        mem_we = 1'b1; mem_addr = h_r; mem_wd = mem_q & ~USED;
        t_nxt = mem_q; state_nxt = S_L2;
      end
      S_L2: begin
        mem_re = 1'b1; mem_addr = h_r + A_HDR + t_r[ADDR_W-1:0];
        f_nxt = h_r + A_HDR + t_r[ADDR_W-1:0]; state_nxt = S_L3;
      end
      S_L3: begin
        mem_we = 1'b1; mem_addr = f_r; mem_wd = mem_q & ~USED; state_nxt = S_L4;
      end
      S_L4: begin mem_re = 1'b1; mem_addr = h_r; state_nxt = S_L5; end
      S_L5: begin
        f_nxt = h_r + A_HDR + mem_q[ADDR_W-1:0];
        if (h_r != '0) begin
          r_nxt = h_r - A_ONE;
          mem_re = 1'b1; mem_addr = h_r - A_ONE; state_nxt = S_L6;
        end else begin
          state_nxt = S_N0;
        end
      end
      S_L6: begin
        if (!mem_q[USED_BIT]) begin
          n_nxt = r_r - mem_q[ADDR_W-1:0] - A_HDR;
          mem_re = 1'b1; mem_addr = r_r - mem_q[ADDR_W-1:0] - A_HDR;
          state_nxt = S_L7;
        end else begin
          state_nxt = S_N0;
        end
      end
      S_L7: begin t_nxt = mem_q; mem_re = 1'b1; mem_addr = f_r; state_nxt = S_L8; end
      S_L8: begin
        mem_we = 1'b1; mem_addr = n_r; mem_wd = sum; t_nxt = sum; state_nxt = S_L9;
      end
      S_L9: begin mem_we = 1'b1; mem_addr = f_r; mem_wd = t_r; state_nxt = S_DONE; end
      // no left merge: clear flags again and link in after the entry
      S_N0: begin mem_re = 1'b1; mem_addr = h_r; state_nxt = S_N1; end
      S_N1: begin
        mem_we = 1'b1; mem_addr = h_r; mem_wd = mem_q & ~USED;
        t_nxt = mem_q; state_nxt = S_N2;
      end
      S_N2: begin
        mem_re = 1'b1; mem_addr = h_r + A_HDR + t_r[ADDR_W-1:0];
        f_nxt = h_r + A_HDR + t_r[ADDR_W-1:0]; state_nxt = S_N3;
      end
      S_N3: begin
        mem_we = 1'b1; mem_addr = f_r; mem_wd = mem_q & ~USED; state_nxt = S_N4;
      end
      S_N4: begin
        if (ev_r) begin
          mem_re = 1'b1; mem_addr = e_r + A_ONE; state_nxt = S_N5;
        end else begin
          e_nxt = h_r; ev_nxt = 1'b1;
          mem_we = 1'b1; mem_addr = h_r + A_ONE; mem_wd = word_t'(h_r);
          state_nxt = S_N9;
        end
      end
      S_N5: begin
        n_nxt = mem_q[ADDR_W-1:0];
        mem_we = 1'b1; mem_addr = mem_q[ADDR_W-1:0] + A_TWO; mem_wd = word_t'(h_r);
        state_nxt = S_N6;
      end
      S_N6: begin
        mem_we = 1'b1; mem_addr = h_r + A_ONE; mem_wd = word_t'(n_r); state_nxt = S_N7;
      end
      S_N7: begin
        mem_we = 1'b1; mem_addr = h_r + A_TWO; mem_wd = word_t'(e_r); state_nxt = S_N8;
      end
      S_N8: begin
        mem_we = 1'b1; mem_addr = e_r + A_ONE; mem_wd = word_t'(h_r); state_nxt = S_DONE;
      end
      S_N9: begin
        mem_we = 1'b1; mem_addr = h_r + A_TWO; mem_wd = word_t'(h_r); state_nxt = S_DONE;
      end
      // allocate: first-fit walk from the entry
      S_A0: begin
        if (!ev_r) begin
          fail_nxt = ST_FAIL; state_nxt = S_DONE;
        end else begin
          h_nxt = e_r; steps_nxt = '0;
          mem_re = 1'b1; mem_addr = e_r; state_nxt = S_A1;
        end
      end
      S_A1: begin
        if (mem_q >= word_t'(req_r)) begin
          t_nxt = mem_q; f_nxt = h_r + A_HDR + mem_q[ADDR_W-1:0]; state_nxt = S_A3;
        end else begin
          steps_nxt = steps_r + 1'b1;
          mem_re = 1'b1; mem_addr = h_r + A_ONE; state_nxt = S_A2;
        end
      end
      S_A2: begin
        h_nxt = mem_q[ADDR_W-1:0];
        if (mem_q[ADDR_W-1:0] != e_r && steps_r < STEP_W'(POOL_WORDS)) begin
          mem_re = 1'b1; mem_addr = mem_q[ADDR_W-1:0]; state_nxt = S_A1;
        end else begin
          fail_nxt = ST_FAIL; state_nxt = S_DONE;
        end
      end
      S_A3: begin
        if (t_r > word_t'(req_r) + W_TAG) begin
          // split: the used part comes off the block's end
          n_nxt = f_r - req_r - A_HDR;
          mem_we = 1'b1; mem_addr = f_r; mem_wd = word_t'(req_r) | USED;
          state_nxt = S_A4;
        end else begin
          mem_we = 1'b1; mem_addr = h_r; mem_wd = t_r | USED; state_nxt = S_A7;
        end
      end
      S_A4: begin
        mem_we = 1'b1; mem_addr = n_r; mem_wd = word_t'(req_r) | USED; state_nxt = S_A5;
      end
      S_A5: begin
        mem_we = 1'b1; mem_addr = n_r - A_ONE;
        mem_wd = t_r - W_TAG - word_t'(req_r); state_nxt = S_A6;
      end
      S_A6: begin
        mem_we = 1'b1; mem_addr = h_r; mem_wd = t_r - W_TAG - word_t'(req_r);
        res_nxt = n_r + A_HDR; state_nxt = S_DONE;
      end
      S_A7: begin
        mem_we = 1'b1; mem_addr = f_r; mem_wd = t_r | USED;
        res_nxt = h_r + A_HDR; state_nxt = S_A8;
      end
      S_A8: begin mem_re = 1'b1; mem_addr = h_r + A_ONE; state_nxt = S_A9; end
      S_A9: begin
        if (mem_q[ADDR_W-1:0] == h_r) begin
          ev_nxt = 1'b0; state_nxt = S_DONE;
        end else begin
          e_nxt = mem_q[ADDR_W-1:0]; ev_nxt = 1'b1; n_nxt = mem_q[ADDR_W-1:0];
          mem_re = 1'b1; mem_addr = h_r + A_TWO; state_nxt = S_A10;
        end
      end
      S_A10: begin
        r_nxt = mem_q[ADDR_W-1:0];
        mem_we = 1'b1; mem_addr = n_r + A_TWO; mem_wd = word_t'(mem_q[ADDR_W-1:0]);
        state_nxt = S_A11;
      end
      S_A11: begin
        mem_we = 1'b1; mem_addr = r_r + A_ONE; mem_wd = word_t'(n_r); state_nxt = S_DONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cnt_r    <= '0;
      e_r      <= '0;
      ev_r     <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      e_r      <= e_nxt;
      ev_r     <= ev_nxt;
      ovalid_r <= ovalid_nxt;
    end
    h_r     <= h_nxt;
    f_r     <= f_nxt;
    r_r     <= r_nxt;
    n_r     <= n_nxt;
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    fail_r  <= fail_nxt;
    t_r     <= t_nxt;
    steps_r <= steps_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
  end

  `BTFF_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_r != S_IDLE, "idle after request")
  `BTFF_ASSERT_NOW(a_fail_zero, ovalid_r && ostat_r == ST_FAIL, odata_r == '0, "fail with addr")
  `BTFF_ASSERT_NOW(a_idle_no_write, state_r == S_IDLE, !mem_we && !mem_re, "mem access idle")
  `BTFF_ASSERT_NOW(a_clr_blocks, state_r == S_CLR, !in_ch.ready, "ready during clear")

endmodule
